// ===== rtl/wft_pkg.sv =====
// Package with request/result types, widths and character helpers for the word frequency table.
`default_nettype none
package wft_pkg;

  localparam int WordSlotsDef = 32;
  localparam int WordCharsDef = 50;
  localparam int SlotW  = 5;
  localparam int EntryW = 6;
  localparam int CountW = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } wft_in_t;

  typedef struct packed {
    logic              kind;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] occ_count;
    logic              is_new;
    logic [EntryW-1:0] distinct;
    logic              status;
    logic              last_in_run;
  } wft_out_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic cmp;
    logic first;
    logic hit_upd;
    logic new_upd;
  } wft_cell_ctl_t;

  localparam logic KindWord    = 1'b0;
  localparam logic KindSummary = 1'b1;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a);
  endfunction

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    if ((c >= 8'h41) && (c <= 8'h5a)) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wft_cell.sv =====
// One table slot: stored word, length, count and running match flag, chained to its neighbour.
`default_nettype none
module wft_cell #(
  parameter int WORD_CHARS = wft_pkg::WordCharsDef,
  parameter int IDX        = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire wft_pkg::wft_cell_ctl_t       ctl_i,
  input  wire logic [$clog2(WORD_CHARS)-1:0] pos_i,
  input  wire logic [$clog2(WORD_CHARS)-1:0] tlen_i,
  input  wire logic [7:0]                   ch_i,
  input  wire logic [wft_pkg::EntryW-1:0]   entries_i,
  input  wire logic                         hit_i,
  input  wire logic [wft_pkg::CountW-1:0]   cnt_i,
  input  wire logic [wft_pkg::SlotW-1:0]    idx_i,
  output logic                              hit_o,
  output logic [wft_pkg::CountW-1:0]        cnt_o,
  output logic [wft_pkg::SlotW-1:0]         idx_o,
  output logic                              own_hit_o
);

  localparam int Keep = WORD_CHARS - 1;
  localparam int LW   = $clog2(WORD_CHARS);
  localparam int AW   = (Keep > 1) ? $clog2(Keep) : 1;

  logic [7:0]                 mem [Keep];
  logic [7:0]                 rdata_q;
  logic                       match_q, match_d;
  logic [LW-1:0]              len_q;
  logic [wft_pkg::CountW-1:0] cnt_q;
  logic                       valid;
  logic                       cand;

  assign valid     = entries_i > wft_pkg::EntryW'(IDX);
  assign cand      = entries_i == wft_pkg::EntryW'(IDX);
  assign own_hit_o = valid && match_q && (len_q == tlen_i);
  assign hit_o     = hit_i || own_hit_o;
  assign cnt_o     = own_hit_o ? cnt_q : cnt_i;
  assign idx_o     = own_hit_o ? wft_pkg::SlotW'(IDX) : idx_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && cand) begin
      mem[pos_i[AW-1:0]] <= ch_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[pos_i[AW-1:0]];
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctl_i.cmp) begin
      match_d = (ctl_i.first || match_q) && (pos_i < len_q) && (rdata_q == ch_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hit_upd && own_hit_o && (cnt_q != wft_pkg::CountMax)) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (ctl_i.new_upd && cand) begin
      cnt_q <= wft_pkg::CountW'(1);
      len_q <= tlen_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/word_frequency_table_top.sv =====
// Top level of the word frequency table: request control, slot cell chain and result register.
//
//   channel | valid       | stall       | payload
//   in      | in_valid_i  | in_stall_o  | in_req_i  (wft_in_t)
//   out     | out_valid_o | out_stall_i | out_o     (wft_out_t)
//
// A word byte is written and read in the cell memories, then compared (state S_CMP); a separator
// or dropped byte skips the compare. A completed word adds the chain lookup (S_FIN), a last
// request the summary (S_SUM). The slot memories are read through one registered port per cell.
// Reset clears the table; slot contents are left as they are. A stalled result holds; a
// request that completes a word or a sentence waits for it with the input stalled.
`default_nettype none
module word_frequency_table_top #(
  parameter int WORD_SLOTS = wft_pkg::WordSlotsDef,
  parameter int WORD_CHARS = wft_pkg::WordCharsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire wft_pkg::wft_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output wft_pkg::wft_out_t     out_o
);

  localparam int Keep = WORD_CHARS - 1;
  localparam int LW   = $clog2(WORD_CHARS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [LW-1:0]               tlen_q, tlen_d;
  logic [LW-1:0]               pos_q, pos_d;
  logic [7:0]                  ch_q, ch_d;
  logic                        last_q, last_d;
  logic                        first_q, first_d;
  logic [wft_pkg::EntryW-1:0]  entries_q, entries_d;
  logic                        full_q, full_d;
  logic                        out_valid_q, out_valid_d;
  wft_pkg::wft_out_t           out_q, out_d;
  wft_pkg::wft_cell_ctl_t      ctl;
  logic [LW-1:0]               pos_bc;
  logic [7:0]                  ch_bc;
  logic [7:0]                  ch_low;
  logic                        in_acc;
  logic                        out_ok;
  logic [wft_pkg::CountW-1:0]  cnt_new;

  logic                        hit_c [WORD_SLOTS+1];
  logic [wft_pkg::CountW-1:0]  cnt_c [WORD_SLOTS+1];
  logic [wft_pkg::SlotW-1:0]   idx_c [WORD_SLOTS+1];
  logic [WORD_SLOTS-1:0]       own_hits;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_ok      = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign ch_low      = wft_pkg::lower_char(in_req_i.ch);
  assign pos_bc      = (state_q == S_IDLE) ? tlen_q : pos_q;
  assign ch_bc       = (state_q == S_IDLE) ? ch_low : ch_q;
  assign cnt_new     = (cnt_c[WORD_SLOTS] == wft_pkg::CountMax) ? cnt_c[WORD_SLOTS]
                                                              : cnt_c[WORD_SLOTS] + 1'b1;

  assign hit_c[0] = 1'b0;
  assign cnt_c[0] = '0;
  assign idx_c[0] = '0;

  for (genvar g = 0; g < WORD_SLOTS; g++) begin : g_cell
    wft_cell #(
      .WORD_CHARS(WORD_CHARS),
      .IDX       (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .pos_i    (pos_bc),
      .tlen_i   (tlen_q),
      .ch_i     (ch_bc),
      .entries_i(entries_q),
      .hit_i    (hit_c[g]),
      .cnt_i    (cnt_c[g]),
      .idx_i    (idx_c[g]),
      .hit_o    (hit_c[g+1]),
      .cnt_o    (cnt_c[g+1]),
      .idx_o    (idx_c[g+1]),
      .own_hit_o(own_hits[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    tlen_d      = tlen_q;
    pos_d       = pos_q;
    ch_d        = ch_q;
    last_d      = last_q;
    first_d     = first_q;
    entries_d   = entries_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctl         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d    = ch_low;
          last_d  = in_req_i.last;
          first_d = tlen_q == '0;
          pos_d   = tlen_q;
          if (full_q) begin
            state_d = in_req_i.last ? S_SUM : S_IDLE;
          end else if (wft_pkg::is_sep(in_req_i.ch)) begin
            if (tlen_q != '0) begin
              state_d = S_FIN;
            end else begin
              state_d = in_req_i.last ? S_SUM : S_IDLE;
            end
          end else if (tlen_q < LW'(Keep)) begin
            ctl.wr  = 1'b1;
            ctl.rd  = 1'b1;
            tlen_d  = tlen_q + 1'b1;
            state_d = S_CMP;
          end else begin
            state_d = in_req_i.last ? S_FIN : S_IDLE;
          end
        end
      end
      S_CMP: begin
        ctl.cmp   = 1'b1;
        ctl.first = first_q;
        state_d   = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (hit_c[WORD_SLOTS] || (entries_q < wft_pkg::EntryW'(WORD_SLOTS))) begin
          if (out_ok) begin
            out_valid_d       = 1'b1;
            out_d.kind        = wft_pkg::KindWord;
            out_d.distinct    = '0;
            out_d.status      = 1'b0;
            out_d.last_in_run = !last_q;
            if (hit_c[WORD_SLOTS]) begin
              ctl.hit_upd     = 1'b1;
              out_d.slot      = idx_c[WORD_SLOTS];
              out_d.occ_count = cnt_new;
              out_d.is_new    = 1'b0;
            end else begin
              ctl.new_upd     = 1'b1;
              out_d.slot      = entries_q[wft_pkg::SlotW-1:0];
              out_d.occ_count = wft_pkg::CountW'(1);
              out_d.is_new    = 1'b1;
              entries_d       = entries_q + 1'b1;
            end
            tlen_d  = '0;
            state_d = last_q ? S_SUM : S_IDLE;
          end
        end else begin
          full_d  = 1'b1;
          tlen_d  = '0;
          state_d = last_q ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (out_ok) begin
          out_valid_d       = 1'b1;
          out_d.kind        = wft_pkg::KindSummary;
          out_d.slot        = '0;
          out_d.occ_count   = '0;
          out_d.is_new      = 1'b0;
          out_d.distinct    = entries_q;
          out_d.status      = full_q;
          out_d.last_in_run = 1'b1;
          entries_d         = '0;
          full_d            = 1'b0;
          tlen_d            = '0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tlen_q      <= '0;
      entries_q   <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      tlen_q      <= tlen_d;
      entries_q   <= entries_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    ch_q  <= ch_d;
    out_q <= out_d;
  end

  a_one_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> $onehot0(own_hits))
    else $error("more than one slot matched the word");

  a_entries_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= wft_pkg::EntryW'(WORD_SLOTS))
    else $error("slot count beyond table size");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> entries_q == wft_pkg::EntryW'(WORD_SLOTS))
    else $error("table-full error with free slots");

  a_summary_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && out_ok) |=> (entries_q == '0 && !full_q && tlen_q == '0))
    else $error("table not cleared after summary");

endmodule
`default_nettype wire

// ===== tb/tb_word_frequency_table_top.sv =====
// Testbench for the word frequency table: sentence stimulus, scoreboard and result checks.
`default_nettype none
module tb_word_frequency_table_top;

  localparam int Slots = wft_pkg::WordSlotsDef;
  localparam int Keep  = wft_pkg::WordCharsDef - 1;
  localparam longint CycleLimit = 2000000;

  class wft_scoreboard;
    logic [7:0]  words [Slots][Keep];
    int          lens [Slots];
    logic [15:0] counts [Slots];
    int          used;
    logic [7:0]  tok [Keep];
    int          tok_len;
    bit          full;
    wft_pkg::wft_out_t pending [$];
    int          errors;

    function void clear();
      used = 0;
      tok_len = 0;
      full = 0;
      errors = 0;
      pending.delete();
    endfunction

    function void push_word();
      wft_pkg::wft_out_t r;
      int       n;
      bit       hit;
      n = tok_len;
      tok_len = 0;
      r = '0;
      r.kind = wft_pkg::KindWord;
      for (int i = 0; i < used; i++) begin
        if (lens[i] == n) begin
          hit = 1;
          for (int k = 0; k < n; k++) if (words[i][k] != tok[k]) hit = 0;
          if (hit) begin
            if (counts[i] != wft_pkg::CountMax) counts[i]++;
            r.slot = wft_pkg::SlotW'(i);
            r.occ_count = counts[i];
            pending.push_back(r);
            return;
          end
        end
      end
      if (used >= Slots) begin
        full = 1;
        return;
      end
      for (int k = 0; k < n; k++) words[used][k] = tok[k];
      lens[used] = n;
      counts[used] = 1;
      r.slot = wft_pkg::SlotW'(used);
      r.occ_count = 1;
      r.is_new = 1;
      used++;
      pending.push_back(r);
    endfunction

    function void note_request(wft_pkg::wft_in_t q);
      int         n_prev;
      logic [7:0] c;
      wft_pkg::wft_out_t s;
      n_prev = pending.size();
      if (!full) begin
        if (is_sep_tb(q.ch)) begin
          if (tok_len > 0) push_word();
        end else begin
          c = q.ch;
          if (c >= "A" && c <= "Z") c = c + 8'd32;
          if (tok_len < Keep) begin
            tok[tok_len] = c;
            tok_len++;
          end
          if (q.last) push_word();
        end
        if (full) tok_len = 0;
      end
      if (q.last) begin
        s = '0;
        s.kind = wft_pkg::KindSummary;
        s.distinct = wft_pkg::EntryW'(used);
        s.status = full;
        pending.push_back(s);
        used = 0;
        tok_len = 0;
        full = 0;
      end
      if (pending.size() > n_prev) pending[pending.size()-1].last_in_run = 1'b1;
    endfunction

    function bit is_sep_tb(logic [7:0] c);
      return c == " " || c == "\t" || c == "\n";
    endfunction

    function void check_result(wft_pkg::wft_out_t got);
      wft_pkg::wft_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_stall_o;
  wft_pkg::wft_in_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 0;
  wft_pkg::wft_out_t out_o;

  wft_scoreboard board;
  int  send_idle = 0;
  int  recv_stall = 0;
  longint cycles = 0;
  byte pool [8][6];
  int  pool_len [8];

  word_frequency_table_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_req_i(in_req_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_o);
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{ch: c, last: l};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request('{ch: c, last: l});
  endtask

  task automatic send_text(input string s, input logic l);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], l && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(2))
      0: return " ";
      1: return "\t";
      default: return "\n";
    endcase
  endfunction

  task automatic random_sentence(input int words);
    int w;
    int n;
    logic [7:0] c;
    for (int i = 0; i < words; i++) begin
      w = $urandom_range(7);
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        for (int k = 0; k < pool_len[w]; k++) begin
          c = pool[w][k];
          if ($urandom_range(1)) c = c - 8'd32;
          send_byte(c, 1'b0);
        end
      end
      if ($urandom_range(4) == 0 && i == words - 1) begin
        send_byte(pool[w][0], 1'b1);
        return;
      end
      send_byte(pick_sep(), i == words - 1 && $urandom_range(3) == 0);
    end
    send_byte(pick_sep(), 1'b1);
  endtask

  task automatic unique_words(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte("q", 1'b0);
      send_byte(8'(8'h30 + i / 10), 1'b0);
      send_byte(8'(8'h30 + i % 10), 1'b0);
      send_byte(" ", 1'b0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(input int si, input int rs, input int sentences);
    send_idle = si;
    recv_stall = rs;
    for (int s = 0; s < sentences; s++) begin
      if ($urandom_range(9) == 0) begin
        unique_words($urandom_range(30, 34));
        send_text("q00 x", 1'b1);
      end else begin
        random_sentence($urandom_range(1, 8));
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    board.clear();
    for (int w = 0; w < 8; w++) begin
      pool_len[w] = 1 + w % 5;
      for (int k = 0; k < 6; k++) pool[w][k] = 8'(8'h61 + ((w * 7 + k * 3) % 26));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte("\n", 1'b1);
    send_text("Ab aB\tab\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(" ", 1'b0);
    send_text("Zz", 1'b1);
    for (int i = 0; i < 60; i++) send_byte("a", 1'b0);
    send_byte(" ", 1'b0);
    for (int i = 0; i < 49; i++) send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    unique_words(33);
    send_text("zz q01 ", 1'b1);
    drain();
    for (int i = 0; i < 20; i++) begin
      send_byte("w", 1'b0);
      send_byte(" ", 1'b0);
    end
    send_byte(" ", 1'b1);
    drain();

    run_phase(0, 0, 5);
    run_phase(85, 0, 5);
    run_phase(0, 85, 5);
    run_phase(20, 20, 5);
    run_phase($urandom_range(50), $urandom_range(50), 5);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
